/* design/ego_pkg.sv */
`default_nettype none

package ego_pkg;

   // input word
   typedef struct packed {
      logic signed [15:0] count_x;
      logic signed [15:0] count_y;
      logic signed [15:0] gyro_rate;
      logic        [15:0] period;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [47:0] centre_x;
      logic signed [47:0] centre_y;
      logic signed [31:0] heading;
   } rsp_word_type;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 48;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DISTANCE_PER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_YAW_SCALE          = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET_X           = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET_Y           = 2'd3;

   localparam logic [23:0] DISTANCE_PER_COUNT_RESET = 24'd3087;

   // multiplier operand selects
   localparam logic [1:0] A_CX = 2'd0;
   localparam logic [1:0] A_CY = 2'd1;
   localparam logic [1:0] A_EX = 2'd2;
   localparam logic [1:0] A_EY = 2'd3;

   localparam logic [1:0] B_DPC = 2'd0;
   localparam logic [1:0] B_SIN = 2'd1;
   localparam logic [1:0] B_COS = 2'd2;

   // accumulator operations
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_SUB  = 2'd2;
   localparam logic [1:0] ACC_ADD  = 2'd3;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic       load;
      logic       look;
      logic [1:0] a_sel;
      logic [1:0] b_sel;
      logic       ex_ld;
      logic       ey_ld;
      logic       hinc_ld;
      logic [1:0] acc_op;
      logic       pos_x_ld;
      logic       pos_y_ld;
      logic       head_ld;
      logic       out_ld;
   } cmd_type;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // quarter-wave sine entry in Q15, Taylor series to x^11 in Q30
   function automatic logic [15:0] sine_entry(input int q, input int table_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic signed [63:0] s;
      logic [63:0] r;
      x  = (64'(q) * HALF_PI_Q30) >> (table_bits - 2);
      x2 = (x * x) >> 30;
      t  = x;
      s  = signed'(x);
      t  = ((t * x2) >> 30) / 64'd6;
      s  = s - signed'(t);
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + signed'(t);
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - signed'(t);
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + signed'(t);
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - signed'(t);
      if (s < 0) s = 64'sd0;
      r = (unsigned'(s) + 64'd16384) >> 15;
      return r[15:0];
   endfunction

   // clamp a 49-bit sum into the 48-bit position range
   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      logic signed [47:0] r;
      if (v[48] != v[47]) begin
         r = v[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/ego_ctrl.sv */
`default_nettype none

module ego_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ego_pkg::cmd_type      cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOOK = 4'd1;
   localparam logic [3:0] S_EY   = 4'd2;
   localparam logic [3:0] S_XC   = 4'd3;
   localparam logic [3:0] S_XS   = 4'd4;
   localparam logic [3:0] S_XA   = 4'd5;
   localparam logic [3:0] S_YC   = 4'd6;
   localparam logic [3:0] S_YA   = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.a_sel    = ego_pkg::A_CX;
      cmd.b_sel    = ego_pkg::B_DPC;
      cmd.acc_op   = ego_pkg::ACC_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look  = 1'b1;
            cmd.a_sel = ego_pkg::A_CX;
            cmd.b_sel = ego_pkg::B_DPC;
            state_in  = S_EY;
         end
         S_EY: begin
            cmd.ex_ld   = 1'b1;
            cmd.hinc_ld = 1'b1;
            cmd.a_sel   = ego_pkg::A_CY;
            cmd.b_sel   = ego_pkg::B_DPC;
            state_in    = S_XC;
         end
         S_XC: begin
            cmd.ey_ld = 1'b1;
            cmd.a_sel = ego_pkg::A_EX;
            cmd.b_sel = ego_pkg::B_COS;
            state_in  = S_XS;
         end
         S_XS: begin
            cmd.acc_op = ego_pkg::ACC_LOAD;
            cmd.a_sel  = ego_pkg::A_EY;
            cmd.b_sel  = ego_pkg::B_SIN;
            state_in   = S_XA;
         end
         S_XA: begin
            cmd.acc_op = ego_pkg::ACC_SUB;
            cmd.a_sel  = ego_pkg::A_EX;
            cmd.b_sel  = ego_pkg::B_SIN;
            state_in   = S_YC;
         end
         S_YC: begin
            cmd.pos_x_ld = 1'b1;
            cmd.acc_op   = ego_pkg::ACC_LOAD;
            cmd.a_sel    = ego_pkg::A_EY;
            cmd.b_sel    = ego_pkg::B_COS;
            state_in     = S_YA;
         end
         S_YA: begin
            cmd.acc_op = ego_pkg::ACC_ADD;
            state_in   = S_FIN;
         end
         S_FIN: begin
            cmd.pos_y_ld = 1'b1;
            cmd.head_ld  = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* design/ego_datapath.sv */
`default_nettype none

module ego_datapath #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ego_pkg::cmd_type                       cmd,
   input  wire ego_pkg::req_word_type                  req_data,
   output ego_pkg::rsp_word_type                       rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [ego_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [ego_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   localparam int SB   = SINE_TABLE_BITS;
   localparam int QLEN = 1 << (SB - 2);
   localparam int IW   = SB - 1;
   localparam logic [SB-1:0] QLEN_IDX = SB'(QLEN);
   localparam logic [SB-1:0] HALF_IDX = SB'(1) << (SB - 1);
   localparam logic [31:0]   IDX_ROUND = 32'd1 << (31 - SB);

   // configuration registers
   logic        [23:0] dpc_ff;
   logic        [31:0] yaw_ff;
   logic signed [47:0] off_x_ff;
   logic signed [47:0] off_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff   <= ego_pkg::DISTANCE_PER_COUNT_RESET;
         yaw_ff   <= '0;
         off_x_ff <= '0;
         off_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ego_pkg::REG_DISTANCE_PER_COUNT: dpc_ff   <= csr_data[23:0];
            ego_pkg::REG_YAW_SCALE:          yaw_ff   <= csr_data[31:0];
            ego_pkg::REG_OFFSET_X:           off_x_ff <= csr_data;
            ego_pkg::REG_OFFSET_Y:           off_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // quarter-wave sine table, built at elaboration
   logic [15:0] quarter_rom [0:QLEN];

   for (genvar q = 0; q <= QLEN; q++) begin : g_rom
      assign quarter_rom[q] = ego_pkg::sine_entry(q, SB);
   end

   function automatic logic [16:0] sine_lookup(input logic [SB-1:0] idx);
      logic [SB-1:0] j;
      logic [IW-1:0] k;
      logic [16:0]   mag;
      j = {1'b0, idx[SB-2:0]};
      if (j > QLEN_IDX) j = HALF_IDX - j;
      k   = j[IW-1:0];
      mag = {1'b0, quarter_rom[k]};
      return idx[SB-1] ? (17'd0 - mag) : mag;
   endfunction

   // input capture
   ego_pkg::req_word_type in_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) in_ff <= req_data;
   end

   // state
   logic signed [47:0] pos_x_ff;
   logic signed [47:0] pos_y_ff;
   logic        [31:0] heading_ff;

   // sine and cosine of the held heading
   logic [31:0]    head_round;
   logic [SB-1:0]  sin_idx;
   logic [SB-1:0]  cos_idx;
   logic [16:0]    sin_ff;
   logic [16:0]    cos_ff;

   assign head_round = heading_ff + IDX_ROUND;
   assign sin_idx    = head_round[31 -: SB];
   assign cos_idx    = sin_idx + QLEN_IDX;

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         sin_ff <= sine_lookup(sin_idx);
         cos_ff <= sine_lookup(cos_idx);
      end
   end

   // distance and rotation multiplier
   logic signed [39:0] op_a;
   logic signed [24:0] op_b;
   logic signed [64:0] mul_a_full;
   logic signed [57:0] prod_ff;
   logic signed [39:0] ex_ff;
   logic signed [39:0] ey_ff;

   always_comb begin
      case (cmd.a_sel)
         ego_pkg::A_CX: op_a = {{24{in_ff.count_x[15]}}, in_ff.count_x};
         ego_pkg::A_CY: op_a = {{24{in_ff.count_y[15]}}, in_ff.count_y};
         ego_pkg::A_EX: op_a = ex_ff;
         default:       op_a = ey_ff;
      endcase
      case (cmd.b_sel)
         ego_pkg::B_SIN: op_b = {{8{sin_ff[16]}}, sin_ff};
         ego_pkg::B_COS: op_b = {{8{cos_ff[16]}}, cos_ff};
         default:        op_b = {1'b0, dpc_ff};
      endcase
   end

   assign mul_a_full = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a_full[57:0];
      if (cmd.ex_ld) ex_ff <= prod_ff[39:0];
      if (cmd.ey_ld) ey_ff <= prod_ff[39:0];
   end

   // rotation accumulator
   logic signed [57:0] acc_ff;

   always_ff @(posedge clock) begin
      case (cmd.acc_op)
         ego_pkg::ACC_LOAD: acc_ff <= prod_ff;
         ego_pkg::ACC_SUB:  acc_ff <= acc_ff - prod_ff;
         ego_pkg::ACC_ADD:  acc_ff <= acc_ff + prod_ff;
         default:           acc_ff <= acc_ff;
      endcase
   end

   // heading increment multiplier
   logic signed [32:0] rp_full;
   logic signed [31:0] rp_ff;
   logic signed [65:0] hinc_full;
   logic        [31:0] hinc_ff;

   assign rp_full   = in_ff.gyro_rate * $signed({1'b0, in_ff.period});
   assign hinc_full = $signed({rp_ff[31], rp_ff}) * $signed({1'b0, yaw_ff});

   always_ff @(posedge clock) begin
      if (cmd.look)    rp_ff   <= rp_full[31:0];
      if (cmd.hinc_ld) hinc_ff <= hinc_full[47:16];
   end

   // rounded step added to the kept position
   logic signed [57:0] acc_round;
   logic signed [42:0] step;
   logic signed [48:0] pos_x_sum;
   logic signed [48:0] pos_y_sum;

   assign acc_round = acc_ff + 58'sd16384;
   assign step      = acc_round[57:15];
   assign pos_x_sum = {pos_x_ff[47], pos_x_ff} + {{6{step[42]}}, step};
   assign pos_y_sum = {pos_y_ff[47], pos_y_ff} + {{6{step[42]}}, step};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         heading_ff <= '0;
      end else begin
         if (cmd.pos_x_ld) pos_x_ff   <= ego_pkg::sat48(pos_x_sum);
         if (cmd.pos_y_ld) pos_y_ff   <= ego_pkg::sat48(pos_y_sum);
         if (cmd.head_ld)  heading_ff <= heading_ff + hinc_ff;
      end
   end

   // result register, centre is position plus offset
   logic signed [48:0]    centre_x_sum;
   logic signed [48:0]    centre_y_sum;
   ego_pkg::rsp_word_type rsp_ff;

   assign centre_x_sum = {pos_x_ff[47], pos_x_ff} + {off_x_ff[47], off_x_ff};
   assign centre_y_sum = {pos_y_ff[47], pos_y_ff} + {off_y_ff[47], off_y_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_ff.centre_x <= ego_pkg::sat48(centre_x_sum);
         rsp_ff.centre_y <= ego_pkg::sat48(centre_y_sum);
         rsp_ff.heading  <= heading_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* design/encoder_gyro_odometry.sv */
`default_nettype none

// channel   direction  handshake           payload
// req_      in         req_valid/req_stall  count_x, count_y, gyro_rate, period
// rsp_      out        rsp_valid/rsp_stall  centre_x, centre_y, heading
// csr_      in         csr_we               csr_index, csr_data
//
// a word is accepted, then passes eight sequencer steps through the
// shared distance/rotation multiplier, then loads the result register once it is free
// reset (synchronous, high) zeroes position and heading and loads register defaults
// req_stall is high from acceptance until the result register is loaded
// a stalled result holds in the output register; the next word enters meanwhile
// and its result waits for the register to free up

module encoder_gyro_odometry #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ego_pkg::req_word_type               req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ego_pkg::rsp_word_type                    rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [ego_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ego_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   ego_pkg::cmd_type cmd;

   // sequencer
   ego_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic and state
   ego_datapath #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire
